/* src/gpc_pkg.sv */
// Shared types, constants and constant functions for the Gaussian product combiner.
package gpc_pkg;

    localparam int VALUE_W = 32;
    localparam int FRAC_W = 16;
    localparam int LATENCY = 81;
    localparam int EXP_LIMIT_SHIFT = 7;
    localparam int EXP_MAX_SHIFT = 40;
    localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [30:0] MAG_MAX = 31'h7fff_ffff;

    typedef struct packed {
        logic [30:0]        scale_a;
        logic signed [31:0] centre_a;
        logic [30:0]        spread_a;
        logic [30:0]        scale_b;
        logic signed [31:0] centre_b;
        logic [30:0]        spread_b;
    } t_req;

    typedef struct packed {
        logic [30:0]        scale_out;
        logic signed [31:0] centre_out;
        logic [30:0]        spread_out;
        logic               saturated;
    } t_res;

    function automatic logic [63:0] isqrt64(input logic [65:0] v);
        logic [65:0] rem;
        logic [65:0] inc;
        logic [65:0] res;
        rem = v;
        res = '0;
        for (int b = 31; b >= 0; b--) begin
            inc = (res << (b + 1)) + (66'd1 << (2 * b));
            if (rem >= inc) begin
                rem = rem - inc;
                res = res | (66'd1 << b);
            end
        end
        return res[63:0];
    endfunction

    // 2^(-2^-k) in Q.32
    function automatic logic [63:0] root_q32(input int k);
        logic [63:0] r;
        r = 64'h8000_0000;
        for (int i = 1; i <= k; i++) begin
            r = isqrt64({r[33:0], 32'h0});
        end
        return r;
    endfunction

endpackage

/* src/gpc_delay.sv */
// Fixed-depth register delay line for data that rides beside the arithmetic units.
module gpc_delay #(
    parameter int W = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        r_pipe[0] <= i_d;
        for (int i = 1; i < DEPTH; i++) begin
            r_pipe[i] <= r_pipe[i-1];
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

/* src/gpc_div.sv */
// Pipelined restoring divider, one quotient bit per stage; numerator must be below den << Q_W.
module gpc_div #(
    parameter int N_W = 64,
    parameter int D_W = 32,
    parameter int Q_W = 32
) (
    input  logic           i_clk,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic [Q_W-1:0] o_quo
);

    localparam int W = ((N_W > D_W + Q_W) ? N_W : D_W + Q_W) + 1;

    logic [N_W-1:0] rem_in [Q_W];
    logic [D_W-1:0] den_in [Q_W];
    logic [Q_W-1:0] quo_in [Q_W];
    logic [N_W-1:0] r_rem  [Q_W];
    logic [D_W-1:0] r_den  [Q_W];
    logic [Q_W-1:0] r_quo  [Q_W];

    for (genvar g = 0; g < Q_W; g++) begin : g_stage
        localparam int B = Q_W - 1 - g;
        logic [W-1:0] sub_w;
        logic [W-1:0] rem_w;
        logic         ge;

        if (g == 0) begin : g_first
            assign rem_in[g] = i_num;
            assign den_in[g] = i_den;
            assign quo_in[g] = '0;
        end else begin : g_next
            assign rem_in[g] = r_rem[g-1];
            assign den_in[g] = r_den[g-1];
            assign quo_in[g] = r_quo[g-1];
        end

        assign sub_w = W'(den_in[g]) << B;
        assign rem_w = W'(rem_in[g]);
        assign ge    = rem_w >= sub_w;

        always_ff @(posedge i_clk) begin
            r_rem[g] <= ge ? N_W'(rem_w - sub_w) : rem_in[g];
            r_den[g] <= den_in[g];
            r_quo[g] <= quo_in[g] | (Q_W'(ge) << B);
        end
    end

    assign o_quo = r_quo[Q_W-1];

endmodule

/* src/gpc_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
module gpc_sqrt #(
    parameter int R_W = 26
) (
    input  logic             i_clk,
    input  logic [2*R_W-1:0] i_val,
    output logic [R_W-1:0]   o_root
);

    localparam int V_W = 2 * R_W;
    localparam int W = V_W + 2;

    logic [V_W-1:0] rem_in  [R_W];
    logic [R_W-1:0] root_in [R_W];
    logic [V_W-1:0] r_rem   [R_W];
    logic [R_W-1:0] r_root  [R_W];

    for (genvar g = 0; g < R_W; g++) begin : g_stage
        localparam int B = R_W - 1 - g;
        logic [W-1:0] inc;
        logic         ge;

        if (g == 0) begin : g_first
            assign rem_in[g]  = i_val;
            assign root_in[g] = '0;
        end else begin : g_next
            assign rem_in[g]  = r_rem[g-1];
            assign root_in[g] = r_root[g-1];
        end

        // (r + 2^b)^2 - r^2
        assign inc = (W'(root_in[g]) << (B + 1)) + (W'(1) << (2 * B));
        assign ge  = W'(rem_in[g]) >= inc;

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= ge ? V_W'(W'(rem_in[g]) - inc) : rem_in[g];
            r_root[g] <= root_in[g] | (R_W'(ge) << B);
        end
    end

    assign o_root = r_root[R_W-1];

endmodule

/* src/gpc_exp.sv */
// Pipelined 2^-y evaluation: one root-table multiply per fraction bit, then the integer shift.
module gpc_exp (
    input  logic        i_clk,
    input  logic [23:0] i_y,
    output logic [32:0] o_e
);

    localparam int FB = gpc_pkg::FRAC_W;

    logic [32:0]   acc_in [FB];
    logic [FB-1:0] f_in   [FB];
    logic [7:0]    n_in   [FB];
    logic [32:0]   r_acc  [FB];
    logic [FB-1:0] r_f    [FB];
    logic [7:0]    r_n    [FB];

    for (genvar g = 0; g < FB; g++) begin : g_stage
        localparam logic [31:0] ROOT = 32'(gpc_pkg::root_q32(g + 1));
        logic [65:0] prod;

        if (g == 0) begin : g_first
            assign acc_in[g] = 33'h1_0000_0000;
            assign f_in[g]   = i_y[FB-1:0];
            assign n_in[g]   = i_y[23:FB];
        end else begin : g_next
            assign acc_in[g] = r_acc[g-1];
            assign f_in[g]   = r_f[g-1];
            assign n_in[g]   = r_n[g-1];
        end

        assign prod = 66'(acc_in[g]) * 66'(ROOT) + (66'd1 << 31);

        always_ff @(posedge i_clk) begin
            r_acc[g] <= f_in[g][FB-1-g] ? prod[64:32] : acc_in[g];
            r_f[g]   <= f_in[g];
            r_n[g]   <= n_in[g];
        end
    end

    logic [33:0] rnd;
    logic [32:0] n_e;
    logic [32:0] r_e;

    always_comb begin
        rnd = '0;
        if (r_n[FB-1] > 8'(gpc_pkg::EXP_MAX_SHIFT)) begin
            n_e = '0;
        end else if (r_n[FB-1] == 8'd0) begin
            n_e = r_acc[FB-1];
        end else begin
            rnd = {1'b0, r_acc[FB-1]} + (34'd1 << (r_n[FB-1] - 8'd1));
            n_e = 33'(rnd >> r_n[FB-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
    end

    assign o_e = r_e;

endmodule

/* src/gaussian_product_combiner.sv */
// Top level: product of two scaled Gaussians in Q15.16, fully pipelined.
// Throughput: one request per cycle; busy is high only while reset is held.
// Depth is set by the chained bit-serial stages: exponent-argument divide, root-table
// multiplies and the final scale divide.
// Reset (synchronous, active low) clears the valid line; the result strobe never stalls.
module gaussian_product_combiner (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  gpc_pkg::t_req     i_req,
    output logic              o_busy,
    output logic              o_done,
    output gpc_pkg::t_res     o_res
);

    localparam int LAT = gpc_pkg::LATENCY;

    assign o_busy = ~i_rst_n;

    // valid line
    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start};
        end
    end
    assign o_done = r_vld[LAT-1];

    // stage A: operands, spread fixup
    logic [30:0]        r_ca, r_cb, r_va, r_vb;
    logic signed [31:0] r_ma, r_mb;
    logic [31:0]        r_vsum_a;
    logic [30:0]        va_fix, vb_fix;

    assign va_fix = (i_req.spread_a == 31'd0) ? 31'd1 : i_req.spread_a;
    assign vb_fix = (i_req.spread_b == 31'd0) ? 31'd1 : i_req.spread_b;

    always_ff @(posedge i_clk) begin
        r_ca     <= i_req.scale_a;
        r_cb     <= i_req.scale_b;
        r_ma     <= i_req.centre_a;
        r_mb     <= i_req.centre_b;
        r_va     <= va_fix;
        r_vb     <= vb_fix;
        r_vsum_a <= 32'(va_fix) + 32'(vb_fix);
    end

    // stage B: products
    logic [61:0]        r_varnum_b;
    logic signed [63:0] r_mt1, r_mt2;
    logic signed [32:0] r_diff;
    logic [34:0]        r_tp_b;
    logic [61:0]        r_p_b;
    logic [31:0]        r_vsum_b;
    logic [63:0]        tp_full;

    assign tp_full = 64'(r_vsum_a) * 64'(gpc_pkg::TWO_PI_Q28) + (64'd1 << 27);

    always_ff @(posedge i_clk) begin
        r_varnum_b <= r_va * r_vb + 62'(r_vsum_a >> 1);
        r_mt1      <= r_ma * $signed({1'b0, r_vb});
        r_mt2      <= r_mb * $signed({1'b0, r_va});
        r_diff     <= 33'(r_ma) - 33'(r_mb);
        r_tp_b     <= tp_full[62:28];
        r_p_b      <= r_ca * r_cb;
        r_vsum_b   <= r_vsum_a;
    end

    // stage C: mean numerator magnitude, squared distance
    logic signed [63:0] num_sum;
    logic [32:0]        dmag;
    logic               r_neg_c;
    logic [62:0]        r_mag;
    logic [64:0]        r_dd;
    logic [61:0]        r_varnum_c;
    logic [34:0]        r_tp_c;
    logic [61:0]        r_p_c;
    logic [31:0]        r_vsum_c;

    assign num_sum = r_mt1 + r_mt2;
    assign dmag    = r_diff[32] ? 33'(-r_diff) : 33'(r_diff);

    always_ff @(posedge i_clk) begin
        r_neg_c    <= num_sum[63];
        r_mag      <= num_sum[63] ? 63'(-num_sum) : 63'(num_sum);
        r_dd       <= dmag * dmag;
        r_varnum_c <= r_varnum_b;
        r_tp_c     <= r_tp_b;
        r_p_c      <= r_p_b;
        r_vsum_c   <= r_vsum_b;
    end

    // stage D: divider and root operands
    logic [63:0] r_mnum;
    logic        r_far_d;
    logic [55:0] r_xnum;
    logic [32:0] r_xden;
    logic [51:0] r_sq;
    logic [61:0] r_varnum_d;
    logic [31:0] r_vsum_d;
    logic [61:0] r_p_d;
    logic        r_neg_d;
    logic        far_n;

    assign far_n = r_dd >= 65'({r_vsum_c, 23'h0});

    always_ff @(posedge i_clk) begin
        r_mnum     <= 64'(r_mag) + 64'(r_vsum_c >> 1);
        r_far_d    <= far_n;
        r_xnum     <= far_n ? 56'd0 : 56'(r_dd + 65'(r_vsum_c));
        r_xden     <= {r_vsum_c, 1'b0};
        r_sq       <= {1'b0, r_tp_c, 16'h0};
        r_varnum_d <= r_varnum_c;
        r_vsum_d   <= r_vsum_c;
        r_p_d      <= r_p_c;
        r_neg_d    <= r_neg_c;
    end

    // arithmetic units
    logic [30:0] var_q;
    logic [32:0] mean_q;
    logic [23:0] x_q;
    logic [25:0] root_q;

    gpc_div #(.N_W(62), .D_W(32), .Q_W(31)) u_var_div (
        .i_clk(i_clk), .i_num(r_varnum_d), .i_den(r_vsum_d), .o_quo(var_q)
    );

    gpc_div #(.N_W(64), .D_W(32), .Q_W(33)) u_mean_div (
        .i_clk(i_clk), .i_num(r_mnum), .i_den(r_vsum_d), .o_quo(mean_q)
    );

    gpc_div #(.N_W(56), .D_W(33), .Q_W(24)) u_x_div (
        .i_clk(i_clk), .i_num(r_xnum), .i_den(r_xden), .o_quo(x_q)
    );

    gpc_sqrt #(.R_W(26)) u_sqrt (
        .i_clk(i_clk), .i_val(r_sq), .o_root(root_q)
    );

    // x in Q.16 to log2 units
    logic [54:0] y_full;
    logic [23:0] r_y;
    logic [32:0] e_q;

    assign y_full = 55'(x_q) * 55'(gpc_pkg::LOG2E_Q30) + (55'd1 << 29);

    always_ff @(posedge i_clk) begin
        r_y <= y_full[53:30];
    end

    gpc_exp u_exp (
        .i_clk(i_clk), .i_y(r_y), .o_e(e_q)
    );

    // side data aligned to the exponent result; the root is aligned to the scale numerator
    logic        far_e;
    logic [61:0] p_e;
    logic [25:0] root_g;

    gpc_delay #(.W(1),  .DEPTH(42)) u_far_dly  (.i_clk(i_clk), .i_d(r_far_d), .o_q(far_e));
    gpc_delay #(.W(62), .DEPTH(42)) u_p_dly    (.i_clk(i_clk), .i_d(r_p_d),   .o_q(p_e));
    gpc_delay #(.W(26), .DEPTH(18)) u_root_dly (.i_clk(i_clk), .i_d(root_q),  .o_q(root_g));

    // scale numerator
    logic [32:0] e_eff;
    logic [62:0] r_ph;
    logic [65:0] r_pl;
    logic [63:0] r_g;

    assign e_eff = far_e ? 33'd0 : e_q;

    always_ff @(posedge i_clk) begin
        r_ph <= 63'(p_e[61:32]) * 63'(e_eff);
        r_pl <= 66'(p_e[31:0]) * 66'(e_eff) + (66'd1 << 31);
        r_g  <= 64'(r_ph) + 64'(r_pl[65:32]);
    end

    // overflow check and scale divide operands
    logic [25:0] root_fix;
    logic [63:0] snum;
    logic        sovf;
    logic [63:0] r_snum;
    logic [25:0] r_sden;
    logic        r_sovf;

    assign root_fix = (root_g == 26'd0) ? 26'd1 : root_g;
    assign snum     = r_g + 64'(root_fix >> 1);
    assign sovf     = snum >= 64'({root_fix, 31'h0});

    always_ff @(posedge i_clk) begin
        r_snum <= sovf ? 64'd0 : snum;
        r_sden <= root_fix;
        r_sovf <= sovf;
    end

    logic [30:0] scale_q;

    gpc_div #(.N_W(64), .D_W(26), .Q_W(31)) u_scale_div (
        .i_clk(i_clk), .i_num(r_snum), .i_den(r_sden), .o_quo(scale_q)
    );

    // alignment to the scale quotient
    logic        ovf_o;
    logic [30:0] var_o;
    logic [32:0] mean_o;
    logic        neg_o;

    gpc_delay #(.W(1),  .DEPTH(31)) u_ovf_dly  (.i_clk(i_clk), .i_d(r_sovf),  .o_q(ovf_o));
    gpc_delay #(.W(31), .DEPTH(45)) u_var_dly  (.i_clk(i_clk), .i_d(var_q),   .o_q(var_o));
    gpc_delay #(.W(33), .DEPTH(43)) u_mean_dly (.i_clk(i_clk), .i_d(mean_q),  .o_q(mean_o));
    gpc_delay #(.W(1),  .DEPTH(76)) u_neg_dly  (.i_clk(i_clk), .i_d(r_neg_d), .o_q(neg_o));

    // output register
    logic signed [31:0] centre_n;
    gpc_pkg::t_res      n_res;
    gpc_pkg::t_res      r_res;

    always_comb begin
        if (neg_o) begin
            if (mean_o > (33'd1 << 31)) begin
                centre_n = 32'sh8000_0000;
            end else begin
                centre_n = -$signed(32'(mean_o));
            end
        end else begin
            if (mean_o > 33'(gpc_pkg::MAG_MAX)) begin
                centre_n = 32'sh7fff_ffff;
            end else begin
                centre_n = $signed(32'(mean_o));
            end
        end
        n_res.scale_out  = ovf_o ? gpc_pkg::MAG_MAX : scale_q;
        n_res.centre_out = centre_n;
        n_res.spread_out = var_o;
        n_res.saturated  = ovf_o;
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

/* src/gpc_checker.sv */
// Port-level checker for the Gaussian product combiner, bound to the top level.
module gpc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input gpc_pkg::t_req i_req,
    input logic          o_busy,
    input logic          o_done,
    input gpc_pkg::t_res o_res
);

    a_req_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##81 o_done)
        else $error("accepted request produced no result");

    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, gpc_pkg::LATENCY))
        else $error("result without matching request");

    a_sat_clips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.saturated) |-> (o_res.scale_out == gpc_pkg::MAG_MAX))
        else $error("saturated result not clipped");

endmodule

bind gaussian_product_combiner gpc_checker u_gpc_checker (.*);
